// File: hw/rtl/comfs_pkg.sv
// ----------------------------------------------------------------------------
// comfs_pkg
// Shared types and constants for the center-of-mass frame shift block.
// ----------------------------------------------------------------------------
package comfs_pkg;

	localparam int MASS_W   = 24;
	localparam int COORD_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int ERR_W    = 2;
	localparam int NUM_AXES = 6;

	localparam logic [ERR_W-1:0] ERR_OK        = ERR_W'(0);
	localparam logic [ERR_W-1:0] ERR_MASS_ZERO = ERR_W'(1);
	localparam logic [ERR_W-1:0] ERR_DROPPED   = ERR_W'(2);

	typedef struct packed {
		logic        [MASS_W-1:0]  mass;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
		logic signed [COORD_W-1:0] vel_z;
		logic                      last_body;
	} body_in_t;

	typedef struct packed {
		logic        [INDEX_W-1:0] body_index;
		logic signed [COORD_W-1:0] out_pos_x;
		logic signed [COORD_W-1:0] out_pos_y;
		logic signed [COORD_W-1:0] out_pos_z;
		logic signed [COORD_W-1:0] out_vel_x;
		logic signed [COORD_W-1:0] out_vel_y;
		logic signed [COORD_W-1:0] out_vel_z;
		logic        [ERR_W-1:0]   error_code;
		logic                      last_result;
	} body_out_t;

	typedef struct packed {
		logic             load;
		logic             acc;
		logic             clear;
		logic             div_start;
		logic             div_step;
		logic             div_finish;
		logic             rd_en;
		logic             out_load;
		logic             out_last;
		logic [ERR_W-1:0] err;
	} ctrl_cmd_t;

endpackage

// File: hw/rtl/comfs_if.sv
// ----------------------------------------------------------------------------
// comfs_if
// Valid/ready channels for body input and shifted body output.
// ----------------------------------------------------------------------------
interface comfs_in_if;
	logic                valid;
	logic                ready;
	comfs_pkg::body_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface comfs_out_if;
	logic                 valid;
	logic                 ready;
	comfs_pkg::body_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/comfs_ctrl.sv
// ----------------------------------------------------------------------------
// comfs_ctrl
// Sequencer: load, pipeline drain, division steps, finish, emit with output stall.
// ----------------------------------------------------------------------------
module comfs_ctrl #(
	parameter int MAX_BODIES = 64,
	parameter int COORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_last,
	input  logic                    out_ready,
	input  logic                    mass_zero,
	output logic                    in_ready,
	output logic                    out_valid,
	output comfs_pkg::ctrl_cmd_t    cmd,
	output logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] wr_addr,
	output logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_addr
);

	localparam int NW  = $clog2(MAX_BODIES + 1);
	localparam int AW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int SCW = $clog2(COORD_BITS);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_FLUSH = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]                  state_q;
	logic [NW-1:0]               count_q;
	logic                        ovf_q;
	logic                        v_s1;
	logic                        v_s2;
	logic [SCW-1:0]              step_q;
	logic [comfs_pkg::ERR_W-1:0] err_q;
	logic [NW-1:0]               rd_idx_q;
	logic                        rd_valid_s1;
	logic                        rd_last_s1;
	logic                        out_valid_q;

	logic accept;
	logic store;
	logic flushed;
	logic out_free;
	logic out_load;
	logic rd_more;
	logic rd_en;
	logic emit_done;

	always_comb begin
		accept    = (state_q == S_LOAD) && in_valid;
		store     = accept && (count_q < NW'(MAX_BODIES));
		flushed   = !v_s1 && !v_s2;
		out_free  = !out_valid_q || out_ready;
		out_load  = rd_valid_s1 && out_free;
		rd_more   = rd_idx_q < count_q;
		rd_en     = (state_q == S_EMIT) && rd_more && (!rd_valid_s1 || out_load);
		emit_done = (state_q == S_EMIT) && !rd_more && !rd_valid_s1;
	end

	always_comb begin
		cmd.load       = store;
		cmd.acc        = v_s2;
		cmd.clear      = emit_done;
		cmd.div_start  = (state_q == S_FLUSH) && flushed;
		cmd.div_step   = (state_q == S_DIV);
		cmd.div_finish = (state_q == S_FIN);
		cmd.rd_en      = rd_en;
		cmd.out_load   = out_load;
		cmd.out_last   = rd_last_s1;
		cmd.err        = err_q;
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = out_valid_q;
	assign wr_addr   = count_q[AW-1:0];
	assign rd_addr   = rd_idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			step_q      <= '0;
			err_q       <= comfs_pkg::ERR_OK;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= store;
			v_s2        <= v_s1;
			rd_valid_s1 <= rd_en || (rd_valid_s1 && !out_load);
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			if (store) begin
				count_q <= count_q + NW'(1);
			end
			if (accept && !store) begin
				ovf_q <= 1'b1;
			end
			if (rd_en) begin
				rd_idx_q   <= rd_idx_q + NW'(1);
				rd_last_s1 <= (rd_idx_q + NW'(1)) == count_q;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept && in_last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (flushed) begin
						state_q <= S_DIV;
						step_q  <= '0;
						if (mass_zero) begin
							err_q <= comfs_pkg::ERR_MASS_ZERO;
						end else if (ovf_q) begin
							err_q <= comfs_pkg::ERR_DROPPED;
						end else begin
							err_q <= comfs_pkg::ERR_OK;
						end
					end
				end
				S_DIV: begin
					step_q <= step_q + SCW'(1);
					if (step_q == SCW'(COORD_BITS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q  <= S_EMIT;
					rd_idx_q <= '0;
				end
				S_EMIT: begin
					if (emit_done) begin
						state_q <= S_LOAD;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/comfs_dp.sv
// ----------------------------------------------------------------------------
// comfs_dp
// Datapath: body store, weighted accumulation, six restoring dividers,
// subtract and output register.
// ----------------------------------------------------------------------------
module comfs_dp #(
	parameter int MAX_BODIES = 64,
	parameter int COORD_BITS = 32,
	parameter int MASS_BITS  = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  comfs_pkg::ctrl_cmd_t    cmd,
	input  comfs_pkg::body_in_t     in_data,
	input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] wr_addr,
	input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_addr,
	output logic                    mass_zero,
	output comfs_pkg::body_out_t    out_data
);

	localparam int NA    = comfs_pkg::NUM_AXES;
	localparam int AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CB    = COORD_BITS;
	localparam int TW    = MASS_BITS + $clog2(MAX_BODIES);
	localparam int PW    = MASS_BITS + COORD_BITS + 1;
	localparam int SW    = PW + $clog2(MAX_BODIES);
	localparam int OUT_W = comfs_pkg::COORD_W;
	localparam int IDX_W = comfs_pkg::INDEX_W;

	logic        [TW-1:0]    total_q;
	logic signed [SW-1:0]    sums_q   [NA];
	logic        [MASS_BITS-1:0] m_s1;
	logic signed [CB-1:0]    c_s1     [NA];
	logic signed [PW-1:0]    prod_s2  [NA];
	logic        [TW-1:0]    rem_q    [NA];
	logic        [CB-1:0]    quo_q    [NA];
	logic                    neg_q    [NA];
	logic        [CB-1:0]    ctr_q    [NA];
	logic        [NA*CB-1:0] mem      [MAX_BODIES];
	logic        [NA*CB-1:0] rdata_s1;
	logic        [AW-1:0]    idx_s1;
	comfs_pkg::body_out_t    out_q;

	logic signed [CB-1:0]    c_in     [NA];
	logic        [NA*CB-1:0] wdata;
	logic        [SW-1:0]    abs_sum  [NA];
	logic        [TW:0]      trial    [NA];
	logic        [TW:0]      trial_sub[NA];
	logic                    ge       [NA];
	logic signed [CB-1:0]    sub      [NA];

	always_comb begin
		c_in[0] = in_data.pos_x[CB-1:0];
		c_in[1] = in_data.pos_y[CB-1:0];
		c_in[2] = in_data.pos_z[CB-1:0];
		c_in[3] = in_data.vel_x[CB-1:0];
		c_in[4] = in_data.vel_y[CB-1:0];
		c_in[5] = in_data.vel_z[CB-1:0];
		for (int a = 0; a < NA; a++) begin
			wdata[a*CB +: CB] = c_in[a];
			abs_sum[a]   = sums_q[a][SW-1] ? -sums_q[a] : sums_q[a];
			trial[a]     = {rem_q[a], quo_q[a][CB-1]};
			trial_sub[a] = trial[a] - {1'b0, total_q};
			ge[a]        = trial[a] >= {1'b0, total_q};
			sub[a]       = rdata_s1[a*CB +: CB] - ctr_q[a];
		end
	end

	assign mass_zero = (total_q == '0);
	assign out_data  = out_q;

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int a = 0; a < NA; a++) begin
				sums_q[a] <= '0;
			end
		end else if (cmd.clear) begin
			total_q <= '0;
			for (int a = 0; a < NA; a++) begin
				sums_q[a] <= '0;
			end
		end else begin
			if (cmd.load) begin
				total_q <= total_q + TW'(in_data.mass[MASS_BITS-1:0]);
			end
			if (cmd.acc) begin
				for (int a = 0; a < NA; a++) begin
					sums_q[a] <= sums_q[a] + SW'(prod_s2[a]);
				end
			end
		end
	end

	// multiply pipeline and dividers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_s1 <= in_data.mass[MASS_BITS-1:0];
			for (int a = 0; a < NA; a++) begin
				c_s1[a] <= c_in[a];
			end
		end
		for (int a = 0; a < NA; a++) begin
			prod_s2[a] <= $signed({1'b0, m_s1}) * c_s1[a];
		end
		if (cmd.div_start) begin
			for (int a = 0; a < NA; a++) begin
				neg_q[a] <= sums_q[a][SW-1];
				rem_q[a] <= abs_sum[a][SW-2:CB];
				quo_q[a] <= abs_sum[a][CB-1:0];
			end
		end else if (cmd.div_step) begin
			for (int a = 0; a < NA; a++) begin
				rem_q[a] <= ge[a] ? trial_sub[a][TW-1:0] : trial[a][TW-1:0];
				quo_q[a] <= {quo_q[a][CB-2:0], ge[a]};
			end
		end
		if (cmd.div_finish) begin
			for (int a = 0; a < NA; a++) begin
				if (mass_zero) begin
					ctr_q[a] <= '0;
				end else if (neg_q[a]) begin
					ctr_q[a] <= -quo_q[a];
				end else begin
					ctr_q[a] <= quo_q[a];
				end
			end
		end
	end

	// body store
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
			idx_s1   <= rd_addr;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.body_index  <= IDX_W'(idx_s1);
			out_q.out_pos_x   <= OUT_W'(sub[0]);
			out_q.out_pos_y   <= OUT_W'(sub[1]);
			out_q.out_pos_z   <= OUT_W'(sub[2]);
			out_q.out_vel_x   <= OUT_W'(sub[3]);
			out_q.out_vel_y   <= OUT_W'(sub[4]);
			out_q.out_vel_z   <= OUT_W'(sub[5]);
			out_q.error_code  <= cmd.err;
			out_q.last_result <= cmd.out_last;
		end
	end

endmodule

// File: hw/rtl/center_of_mass_frame_shift.sv
// ----------------------------------------------------------------------------
// center_of_mass_frame_shift
// Shifts a set of bodies into their center-of-mass frame.
// ----------------------------------------------------------------------------
// Bodies load one per cycle into an on-chip store of MAX_BODIES entries while
// total mass accumulates directly and the six mass-weighted sums accumulate
// through a two-stage multiply/add pipeline. The transaction marked last_body
// starts the shift: the pipeline drains and the dividers load, then six
// parallel restoring dividers run one quotient bit per cycle to form a
// COORD_BITS-bit quotient, the offsets are formed, then results leave the
// store one per cycle while the output is not stalled (the store read is
// registered), and the accumulators clear once the last result has been
// loaded into the output register. Output stalls lengthen the emit phase.
// Input is held off from the last body until the set has been emitted.
// Zero total mass gives error_code 1 and unshifted bodies; bodies beyond
// capacity are dropped and, if the mass is nonzero, the results get error_code 2.
// ----------------------------------------------------------------------------
module center_of_mass_frame_shift #(
	parameter int MAX_BODIES = 64,
	parameter int COORD_BITS = 32,
	parameter int MASS_BITS  = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	comfs_in_if.sink           body_in,
	comfs_out_if.source        body_out
);

	localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

	comfs_pkg::ctrl_cmd_t cmd;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic                 mass_zero;

	comfs_ctrl #(
		.MAX_BODIES (MAX_BODIES),
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (body_in.valid),
		.in_last   (body_in.data.last_body),
		.out_ready (body_out.ready),
		.mass_zero (mass_zero),
		.in_ready  (body_in.ready),
		.out_valid (body_out.valid),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	comfs_dp #(
		.MAX_BODIES (MAX_BODIES),
		.COORD_BITS (COORD_BITS),
		.MASS_BITS  (MASS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (body_in.data),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.mass_zero (mass_zero),
		.out_data  (body_out.data)
	);

endmodule
